// File: sv/sgh_pkg.sv
// ----------------------------------------------------------------------------
// sgh_pkg
// Types and constants shared by the shot gate with heat budget.
// ----------------------------------------------------------------------------
`default_nettype none

package sgh_pkg;

   // Register map, one 32-bit word per register.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_HEAT_PER_SHOT  = 3'd0;
   localparam logic [2:0] REG_SINGLE_GAP_MS  = 3'd1;
   localparam logic [2:0] REG_BURST_GAP_MS   = 3'd2;
   localparam logic [2:0] REG_FAST_GAP_MS    = 3'd3;
   localparam logic [2:0] REG_BURST_AFTER_MS = 3'd4;

   localparam logic [9:0]  RST_HEAT_PER_SHOT  = 10'd10;
   localparam logic [15:0] RST_SINGLE_GAP_MS  = 16'd200;
   localparam logic [15:0] RST_BURST_GAP_MS   = 16'd833;
   localparam logic [15:0] RST_FAST_GAP_MS    = 16'd100;
   localparam logic [15:0] RST_BURST_AFTER_MS = 16'd100;

   // Shooting modes.
   localparam logic [1:0] MODE_NORMAL  = 2'd0;
   localparam logic [1:0] MODE_FAST    = 2'd1;
   localparam logic [1:0] MODE_REVERSE = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   // Milli-unit scale factors.
   localparam logic [19:0] MILLI_PER_HEAT   = 20'd1000;
   localparam logic [20:0] MILLI_HEADROOM   = 21'd1500;
   localparam logic [25:0] MILLI_PER_HEAT_W = 26'd1000;

   typedef enum logic [1:0] {
      PWR_DEAD   = 2'd0,
      PWR_REVIVE = 2'd1,
      PWR_WORK   = 2'd2
   } sgh_pwr_type;

   typedef struct packed {
      logic [9:0]  heat_per_shot;
      logic [15:0] single_gap_ms;
      logic [15:0] burst_gap_ms;
      logic [15:0] fast_gap_ms;
      logic [15:0] burst_after_ms;
   } sgh_cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        shoot_request;
      logic [1:0]  mode;
      logic        ref_power_on;
      logic        any_motor_on;
      logic        feeder_ready;
      logic        wheels_ready;
      logic [15:0] ref_heat;
      logic [15:0] ref_heat_limit;
      logic [15:0] cooling_per_s;
   } sgh_req_type;

   typedef struct packed {
      sgh_pwr_type pwr;
      logic [31:0] heat_milli;
      logic [31:0] held_ms;
      logic [31:0] last_shot_ms;
      logic [31:0] prev_now_ms;
   } sgh_state_type;

   typedef struct packed {
      logic        fire;
      logic [1:0]  power_state;
      logic [31:0] heat_estimate_milli;
   } sgh_rsp_type;

endpackage

`default_nettype wire

// File: sv/sgh_gate.sv
// ----------------------------------------------------------------------------
// sgh_gate
// One control tick: power state update, heat cooling, hold time and fire gate.
// ----------------------------------------------------------------------------
`default_nettype none

module sgh_gate
   import sgh_pkg::*;
(
   input  sgh_cfg_type   cfg,
   input  sgh_req_type   req,
   input  sgh_state_type cur,
   output sgh_state_type nxt,
   output sgh_rsp_type   rsp
);

   logic [31:0] elapsed;
   logic        pwr_on;
   sgh_pwr_type pwr_new;
   logic [47:0] cool;
   logic [31:0] cooled;
   logic [32:0] held_sum;
   logic [31:0] held_new;
   logic [15:0] gap;
   logic        gap_ok;
   logic [25:0] ref_heat_milli;
   logic [31:0] heat_max;
   logic [33:0] heat_need;
   logic [33:0] limit_milli;
   logic        headroom_ok;
   logic        fire;
   logic [19:0] shot_milli;
   logic [32:0] heat_sum;
   logic [31:0] heat_new;

   always_comb begin
      elapsed = req.now_ms - cur.prev_now_ms;
      pwr_on  = req.ref_power_on | req.any_motor_on;

      if (!pwr_on) begin
         pwr_new = PWR_DEAD;
      end else begin
         case (cur.pwr)
            PWR_DEAD:   pwr_new = PWR_REVIVE;
            PWR_REVIVE: pwr_new = (req.feeder_ready && req.wheels_ready) ? PWR_WORK
                                                                         : PWR_REVIVE;
            PWR_WORK:   pwr_new = PWR_WORK;
            default:    pwr_new = PWR_DEAD;
         endcase
      end

      // Cooling in milli-units is exactly cooling_per_s times elapsed milliseconds.
      cool   = {32'd0, req.cooling_per_s} * {16'd0, elapsed};
      cooled = (cool >= {16'd0, cur.heat_milli}) ? 32'd0
                                                 : cur.heat_milli - cool[31:0];

      held_sum = {1'b0, cur.held_ms} + {1'b0, elapsed};
      if (!req.shoot_request) begin
         held_new = 32'd0;
      end else if (held_sum[32]) begin
         held_new = '1;
      end else begin
         held_new = held_sum[31:0];
      end

      gap = (held_new > {16'd0, cfg.burst_after_ms}) ? cfg.burst_gap_ms
                                                     : cfg.single_gap_ms;

      // Headroom passes when limit - max(ref, local) is at least 1.5 shots.
      ref_heat_milli = {10'd0, req.ref_heat} * MILLI_PER_HEAT_W;
      heat_max  = (cooled > {6'd0, ref_heat_milli}) ? cooled : {6'd0, ref_heat_milli};
      heat_need = {2'd0, heat_max}
                + {13'd0, {11'd0, cfg.heat_per_shot} * MILLI_HEADROOM};
      limit_milli = {8'd0, {10'd0, req.ref_heat_limit} * MILLI_PER_HEAT_W};
      headroom_ok = (limit_milli >= heat_need);

      case (req.mode)
         MODE_NORMAL: begin
            gap_ok = (req.now_ms - cur.last_shot_ms) > {16'd0, gap};
            fire   = req.shoot_request && gap_ok && headroom_ok;
         end
         MODE_FAST: begin
            gap_ok = (req.now_ms - cur.last_shot_ms) > {16'd0, cfg.fast_gap_ms};
            fire   = req.shoot_request && gap_ok;
         end
         default: begin
            gap_ok = 1'b0;
            fire   = 1'b0;
         end
      endcase

      shot_milli = {10'd0, cfg.heat_per_shot} * MILLI_PER_HEAT;
      heat_sum   = {1'b0, cooled} + {13'd0, shot_milli};
      if (!fire) begin
         heat_new = cooled;
      end else if (heat_sum[32]) begin
         heat_new = '1;
      end else begin
         heat_new = heat_sum[31:0];
      end

      nxt.pwr         = pwr_new;
      nxt.prev_now_ms = req.now_ms;
      if (pwr_new == PWR_WORK) begin
         nxt.heat_milli   = heat_new;
         nxt.held_ms      = held_new;
         nxt.last_shot_ms = fire ? req.now_ms : cur.last_shot_ms;
      end else begin
         fire             = 1'b0;
         nxt.heat_milli   = 32'd0;
         nxt.held_ms      = 32'd0;
         nxt.last_shot_ms = cur.last_shot_ms;
      end

      rsp.fire                = fire;
      rsp.power_state         = pwr_new;
      rsp.heat_estimate_milli = nxt.heat_milli;
   end

endmodule

`default_nettype wire

// File: sv/shot_gate_heat_budget.sv
// Result path: the input register takes the request, and the result register
// is written with the tick state when the held request advances.
// Throughput: one request per cycle while rsp_stall is low; the state update
// is a single pass of logic, bounded by the 16 x 32 cooling multiplier feeding
// the heat compares.
// Reset: synchronous, active high; clears valid flags and tick state, and
// loads the register defaults.
// ----------------------------------------------------------------------------
// shot_gate_heat_budget
// Shooter fire gate with power state machine and local heat budget.
// ----------------------------------------------------------------------------
`default_nettype none

module shot_gate_heat_budget
   import sgh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [31:0]           req_now_ms,
   input  wire logic                  req_shoot_request,
   input  wire logic [1:0]            req_mode,
   input  wire logic                  req_ref_power_on,
   input  wire logic                  req_any_motor_on,
   input  wire logic                  req_feeder_ready,
   input  wire logic                  req_wheels_ready,
   input  wire logic [15:0]           req_ref_heat,
   input  wire logic [15:0]           req_ref_heat_limit,
   input  wire logic [15:0]           req_cooling_per_s,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_fire,
   output      logic [1:0]            rsp_power_state,
   output      logic [31:0]           rsp_heat_estimate_milli,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);

   sgh_cfg_type   cfg_ff;
   sgh_cfg_type   cfg_in;
   logic          in_valid_ff;
   logic          in_valid_in;
   sgh_req_type   in_ff;
   sgh_req_type   in_in;
   sgh_state_type state_ff;
   sgh_state_type state_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   sgh_rsp_type   out_ff;
   sgh_rsp_type   out_in;

   sgh_state_type gate_nxt;
   sgh_rsp_type   gate_rsp;
   logic          advance;
   logic          csr_write;
   logic [2:0]    csr_index;

   sgh_gate u_gate (
      .cfg (cfg_ff),
      .req (in_ff),
      .cur (state_ff),
      .nxt (gate_nxt),
      .rsp (gate_rsp)
   );

   // The held request moves on when the result register is empty or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (csr_index)
         REG_HEAT_PER_SHOT:  prdata = {22'd0, cfg_ff.heat_per_shot};
         REG_SINGLE_GAP_MS:  prdata = {16'd0, cfg_ff.single_gap_ms};
         REG_BURST_GAP_MS:   prdata = {16'd0, cfg_ff.burst_gap_ms};
         REG_FAST_GAP_MS:    prdata = {16'd0, cfg_ff.fast_gap_ms};
         REG_BURST_AFTER_MS: prdata = {16'd0, cfg_ff.burst_after_ms};
         default:            prdata = 32'd0;
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_HEAT_PER_SHOT:  cfg_in.heat_per_shot  = pwdata[9:0];
            REG_SINGLE_GAP_MS:  cfg_in.single_gap_ms  = pwdata[15:0];
            REG_BURST_GAP_MS:   cfg_in.burst_gap_ms   = pwdata[15:0];
            REG_FAST_GAP_MS:    cfg_in.fast_gap_ms    = pwdata[15:0];
            REG_BURST_AFTER_MS: cfg_in.burst_after_ms = pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end

      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && !req_stall) begin
         in_valid_in          = 1'b1;
         in_in.now_ms         = req_now_ms;
         in_in.shoot_request  = req_shoot_request;
         in_in.mode           = req_mode;
         in_in.ref_power_on   = req_ref_power_on;
         in_in.any_motor_on   = req_any_motor_on;
         in_in.feeder_ready   = req_feeder_ready;
         in_in.wheels_ready   = req_wheels_ready;
         in_in.ref_heat       = req_ref_heat;
         in_in.ref_heat_limit = req_ref_heat_limit;
         in_in.cooling_per_s  = req_cooling_per_s;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in     = advance ? gate_nxt : state_ff;
      out_in       = advance ? gate_rsp : out_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heat_per_shot  <= RST_HEAT_PER_SHOT;
         cfg_ff.single_gap_ms  <= RST_SINGLE_GAP_MS;
         cfg_ff.burst_gap_ms   <= RST_BURST_GAP_MS;
         cfg_ff.fast_gap_ms    <= RST_FAST_GAP_MS;
         cfg_ff.burst_after_ms <= RST_BURST_AFTER_MS;
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.pwr          <= PWR_DEAD;
         state_ff.heat_milli   <= 32'd0;
         state_ff.held_ms      <= 32'd0;
         state_ff.last_shot_ms <= 32'd0;
         state_ff.prev_now_ms  <= 32'd0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_fire                = out_ff.fire;
   assign rsp_power_state         = out_ff.power_state;
   assign rsp_heat_estimate_milli = out_ff.heat_estimate_milli;

endmodule

`default_nettype wire

// File: bench/shot_gate_heat_budget_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shot_gate_heat_budget_test
// Self-checking bench for the shot gate with heat budget. A directed opening
// walks the power states, gap and headroom boundaries and time wrap. Random
// phases under several register settings follow, plus one run of back-to-back
// fast shots that stacks up heat at the largest step. Every request is run
// through a local model of the gate, and each result is compared against the
// oldest prediction.
// ----------------------------------------------------------------------------

module shot_gate_heat_budget_test;
   import sgh_pkg::*;

   // Tracks the gate's state and queues the tick results it should produce.
   class fire_gate_tracker;
      sgh_cfg_type cfg;
      sgh_pwr_type pwr;
      logic [31:0] heat;
      logic [31:0] held;
      logic [31:0] last_shot;
      logic [31:0] prev_now;
      sgh_rsp_type expected_ticks[$];
      int          errors;

      function new();
         cfg = '{RST_HEAT_PER_SHOT, RST_SINGLE_GAP_MS, RST_BURST_GAP_MS,
                 RST_FAST_GAP_MS, RST_BURST_AFTER_MS};
         pwr = PWR_DEAD;
         heat = '0;
         held = '0;
         last_shot = '0;
         prev_now = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_HEAT_PER_SHOT:  cfg.heat_per_shot  = val[9:0];
            REG_SINGLE_GAP_MS:  cfg.single_gap_ms  = val[15:0];
            REG_BURST_GAP_MS:   cfg.burst_gap_ms   = val[15:0];
            REG_FAST_GAP_MS:    cfg.fast_gap_ms    = val[15:0];
            REG_BURST_AFTER_MS: cfg.burst_after_ms = val[15:0];
            default: ;
         endcase
      endfunction

      function sgh_rsp_type predict_tick(sgh_req_type t);
         sgh_rsp_type r;
         logic [31:0] elapsed;
         logic [31:0] gap;
         logic [63:0] cool;
         logic [63:0] sum;
         longint      hot;
         bit          shot;
         elapsed = t.now_ms - prev_now;
         prev_now = t.now_ms;
         shot = 1'b0;
         if (!(t.ref_power_on || t.any_motor_on)) begin
            pwr = PWR_DEAD;
         end else if (pwr == PWR_DEAD) begin
            pwr = PWR_REVIVE;
         end else if (pwr == PWR_REVIVE && t.feeder_ready && t.wheels_ready) begin
            pwr = PWR_WORK;
         end
         if (pwr == PWR_WORK) begin
            // Cooling per second times milliseconds lands exactly in milli-units.
            cool = 64'(t.cooling_per_s) * 64'(elapsed);
            heat = (cool >= 64'(heat)) ? 32'd0 : heat - cool[31:0];
            if (t.shoot_request) begin
               sum = 64'(held) + 64'(elapsed);
               held = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
               held = '0;
            end
            hot = longint'(t.ref_heat) * 1000;
            if (longint'(heat) > hot) hot = longint'(heat);
            case (t.mode)
               MODE_NORMAL: begin
                  gap = (held > 32'(cfg.burst_after_ms)) ? 32'(cfg.burst_gap_ms)
                                                         : 32'(cfg.single_gap_ms);
                  shot = t.shoot_request && ((t.now_ms - last_shot) > gap) &&
                         (longint'(t.ref_heat_limit) * 1000 - hot >=
                          longint'(cfg.heat_per_shot) * 1500);
               end
               MODE_FAST: begin
                  shot = t.shoot_request &&
                         ((t.now_ms - last_shot) > 32'(cfg.fast_gap_ms));
               end
               default: shot = 1'b0;
            endcase
            if (shot) begin
               last_shot = t.now_ms;
               sum = 64'(heat) + 64'(cfg.heat_per_shot) * 64'd1000;
               heat = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
         end else begin
            heat = '0;
            held = '0;
         end
         r.fire = shot;
         r.power_state = pwr;
         r.heat_estimate_milli = heat;
         return r;
      endfunction

      function void note_request(sgh_req_type t);
         expected_ticks.push_back(predict_tick(t));
      endfunction

      function void check_result(logic fire, logic [1:0] state, logic [31:0] est);
         sgh_rsp_type e;
         if (expected_ticks.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: fire %0d power_state %0d heat %0d",
                     $time, fire, state, est);
         end else begin
            e = expected_ticks.pop_front();
            if (fire !== e.fire) begin
               errors++;
               $display("%0t: fire expected %0d actual %0d", $time, e.fire, fire);
            end
            if (state !== e.power_state) begin
               errors++;
               $display("%0t: power_state expected %0d actual %0d",
                        $time, e.power_state, state);
            end
            if (est !== e.heat_estimate_milli) begin
               errors++;
               $display("%0t: heat_estimate_milli expected %0d actual %0d",
                        $time, e.heat_estimate_milli, est);
            end
         end
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_now_ms = '0;
   logic        req_shoot_request = 1'b0;
   logic [1:0]  req_mode = MODE_NORMAL;
   logic        req_ref_power_on = 1'b0;
   logic        req_any_motor_on = 1'b0;
   logic        req_feeder_ready = 1'b0;
   logic        req_wheels_ready = 1'b0;
   logic [15:0] req_ref_heat = '0;
   logic [15:0] req_ref_heat_limit = '0;
   logic [15:0] req_cooling_per_s = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_fire;
   logic [1:0]  rsp_power_state;
   logic [31:0] rsp_heat_estimate_milli;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   fire_gate_tracker sb = new();

   bit          quiet = 1'b0;
   int          send_odds = 0;
   int          stall_odds = 0;
   int          stall_left = 0;
   bit          trigger = 1'b1;
   logic [31:0] wall_ms = '0;
   int unsigned cycles = 0;

   shot_gate_heat_budget i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_now_ms              (req_now_ms),
      .req_shoot_request       (req_shoot_request),
      .req_mode                (req_mode),
      .req_ref_power_on        (req_ref_power_on),
      .req_any_motor_on        (req_any_motor_on),
      .req_feeder_ready        (req_feeder_ready),
      .req_wheels_ready        (req_wheels_ready),
      .req_ref_heat            (req_ref_heat),
      .req_ref_heat_limit      (req_ref_heat_limit),
      .req_cooling_per_s       (req_cooling_per_s),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_fire                (rsp_fire),
      .rsp_power_state         (rsp_power_state),
      .rsp_heat_estimate_milli (rsp_heat_estimate_milli),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL shot_gate_heat_budget");
         $finish;
      end
   end

   // Random receiver back-pressure in bursts.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_odds) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_fire, rsp_power_state, rsp_heat_estimate_milli);
   end

   task automatic send_tick(input sgh_req_type t);
      req_valid <= 1'b1;
      req_now_ms <= t.now_ms;
      req_shoot_request <= t.shoot_request;
      req_mode <= t.mode;
      req_ref_power_on <= t.ref_power_on;
      req_any_motor_on <= t.any_motor_on;
      req_feeder_ready <= t.feeder_ready;
      req_wheels_ready <= t.wheels_ready;
      req_ref_heat <= t.ref_heat;
      req_ref_heat_limit <= t.ref_heat_limit;
      req_cooling_per_s <= t.cooling_per_s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(t);
      if (!quiet && $urandom_range(0, 99) < send_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // flags holds {ref_power_on, any_motor_on, feeder_ready, wheels_ready}.
   task automatic poke(input logic [31:0] now, input logic shoot, input logic [1:0] mode,
                       input logic [3:0] flags, input logic [15:0] heat,
                       input logic [15:0] limit, input logic [15:0] cool);
      wall_ms = now;
      send_tick('{now, shoot, mode, flags[3], flags[2], flags[1], flags[0],
                  heat, limit, cool});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, val);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [9:0] hps, input logic [15:0] single_gap,
                              input logic [15:0] burst_gap, input logic [15:0] fast_gap,
                              input logic [15:0] burst_after);
      csr_write(REG_HEAT_PER_SHOT, 32'(hps));
      csr_write(REG_SINGLE_GAP_MS, 32'(single_gap));
      csr_write(REG_BURST_GAP_MS, 32'(burst_gap));
      csr_write(REG_FAST_GAP_MS, 32'(fast_gap));
      csr_write(REG_BURST_AFTER_MS, 32'(burst_after));
   endtask

   function automatic int pick_odds();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 8;
         default: return 30;
      endcase
   endfunction

   // Builds the next tick. Tidy ticks keep power on most of the time so the
   // gate gets to the working state; the rest are fully random.
   function automatic sgh_req_type gen_tick(bit tidy);
      sgh_req_type t;
      logic [31:0] dt;
      logic [31:0] aim;
      logic [31:0] g;
      int          pick;
      int          top;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         dt = 32'($urandom_range(0, 250));
      end else if (pick < 77) begin
         dt = 32'($urandom_range(251, 2000));
      end else if (pick < 82) begin
         dt = '0;
      end else if (pick < 95) begin
         // Land on or just past a gap boundary from the last shot.
         case ($urandom_range(0, 2))
            0:       g = 32'(sb.cfg.single_gap_ms);
            1:       g = 32'(sb.cfg.burst_gap_ms);
            default: g = 32'(sb.cfg.fast_gap_ms);
         endcase
         aim = sb.last_shot + g + 32'($urandom_range(0, 1));
         dt = aim - wall_ms;
         if (dt > 32'd100000) dt = 32'($urandom_range(0, 250));
      end else begin
         dt = $urandom();
      end
      if (!tidy) begin
         t.now_ms = $urandom_range(0, 1) ? $urandom() : wall_ms + dt;
         t.shoot_request = 1'($urandom());
         t.mode = 2'($urandom());
         t.ref_power_on = 1'($urandom());
         t.any_motor_on = 1'($urandom());
         t.feeder_ready = 1'($urandom());
         t.wheels_ready = 1'($urandom());
         t.ref_heat = 16'($urandom());
         t.ref_heat_limit = 16'($urandom());
         t.cooling_per_s = 16'($urandom());
      end else begin
         t.now_ms = wall_ms + dt;
         if ($urandom_range(0, 99) < 3) begin
            t.ref_power_on = 1'b0;
            t.any_motor_on = 1'b0;
         end else begin
            case ($urandom_range(0, 2))
               0:       {t.ref_power_on, t.any_motor_on} = 2'b10;
               1:       {t.ref_power_on, t.any_motor_on} = 2'b01;
               default: {t.ref_power_on, t.any_motor_on} = 2'b11;
            endcase
         end
         if ($urandom_range(0, 99) < 60) begin
            t.feeder_ready = 1'b1;
            t.wheels_ready = 1'b1;
         end else begin
            t.feeder_ready = 1'($urandom());
            t.wheels_ready = 1'($urandom());
         end
         if ($urandom_range(0, 99) < 15) trigger = !trigger;
         t.shoot_request = trigger;
         pick = $urandom_range(0, 99);
         if (pick < 55)      t.mode = MODE_NORMAL;
         else if (pick < 85) t.mode = MODE_FAST;
         else if (pick < 93) t.mode = MODE_REVERSE;
         else                t.mode = MODE_NONE;
         t.ref_heat = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 300))
                                                   : 16'($urandom());
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // Put the limit right around one and a half shots of headroom.
            top = (32'(t.ref_heat) > sb.heat / 1000) ? int'(t.ref_heat)
                                                     : int'(sb.heat / 1000);
            top = top + (3 * int'(sb.cfg.heat_per_shot)) / 2
                  + int'($urandom_range(0, 2)) - 1;
            if (top < 0) top = 0;
            if (top > 65535) top = 65535;
            t.ref_heat_limit = 16'(top);
         end else if (pick < 80) begin
            t.ref_heat_limit = 16'($urandom_range(0, 1000));
         end else begin
            t.ref_heat_limit = 16'($urandom());
         end
         pick = $urandom_range(0, 99);
         if (pick < 50)      t.cooling_per_s = 16'($urandom_range(0, 100));
         else if (pick < 80) t.cooling_per_s = '0;
         else                t.cooling_per_s = 16'($urandom());
      end
      wall_ms = t.now_ms;
      return t;
   endfunction

   task automatic run_phase(input int n);
      int noise_left;
      noise_left = 0;
      send_odds = quiet ? 0 : pick_odds();
      stall_odds = quiet ? 0 : pick_odds();
      for (int k = 0; k < n; k++) begin
         if (noise_left == 0 && $urandom_range(0, 49) == 0)
            noise_left = $urandom_range(1, 5);
         if (noise_left > 0) begin
            noise_left--;
            send_tick(gen_tick(1'b0));
         end else begin
            send_tick(gen_tick(1'b1));
         end
         if (k == n / 2 && $urandom_range(0, 2) == 0) drain();
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset register values.
      poke(32'd0,    1'b0, MODE_NORMAL,  4'b0000, 16'd0, 16'd0, 16'd0);
      poke(32'd10,   1'b0, MODE_NORMAL,  4'b1000, 16'd0, 16'd0, 16'd0);
      poke(32'd20,   1'b1, MODE_NORMAL,  4'b0110, 16'd0, 16'd0, 16'd0);
      poke(32'd250,  1'b0, MODE_NORMAL,  4'b0111, 16'd0, 16'd0, 16'd0);
      // Headroom exactly one and a half shots.
      poke(32'd260,  1'b1, MODE_NORMAL,  4'b1011, 16'd0, 16'd15, 16'd0);
      poke(32'd270,  1'b1, MODE_NORMAL,  4'b1000, 16'd0, 16'd1000, 16'd0);
      // Held long enough that the burst gap applies.
      poke(32'd461,  1'b1, MODE_NORMAL,  4'b1000, 16'd0, 16'd1000, 16'd0);
      poke(32'd1094, 1'b0, MODE_NORMAL,  4'b1000, 16'd0, 16'd1000, 16'd0);
      // The local estimate, not the referee heat, sets the headroom here.
      poke(32'd1100, 1'b1, MODE_NORMAL,  4'b1000, 16'd0, 16'd24, 16'd0);
      poke(32'd1101, 1'b1, MODE_NORMAL,  4'b1000, 16'd0, 16'd25, 16'd0);
      poke(32'd1150, 1'b1, MODE_FAST,    4'b1000, 16'd0, 16'd0, 16'd0);
      poke(32'd1202, 1'b1, MODE_FAST,    4'b1000, 16'd0, 16'd0, 16'd0);
      poke(32'd1302, 1'b1, MODE_FAST,    4'b1000, 16'd0, 16'd0, 16'd0);
      poke(32'd1400, 1'b1, MODE_REVERSE, 4'b1000, 16'd0, 16'd0, 16'd100);
      poke(32'd1500, 1'b1, MODE_NONE,    4'b1000, 16'd0, 16'd0, 16'hFFFF);
      poke(32'hFFFF_FFF0, 1'b1, MODE_NORMAL, 4'b1111, 16'hFFFF, 16'hFFFF, 16'd0);
      // A near-full-range step on top of a huge hold saturates the hold time.
      poke(32'hFFFF_FFEF, 1'b1, MODE_NORMAL, 4'b1111, 16'd0, 16'hFFFF, 16'd0);
      poke(32'd5,    1'b1, MODE_FAST,    4'b0100, 16'd0, 16'd0, 16'd0);
      poke(32'd5,    1'b0, MODE_NORMAL,  4'b0000, 16'd0, 16'd0, 16'd0);
      poke(32'd6,    1'b1, MODE_NORMAL,  4'b1000, 16'd0, 16'd0, 16'd0);
      poke(32'd300,  1'b1, MODE_NORMAL,  4'b1011, 16'd0, 16'd100, 16'd0);
      drain();

      run_phase(250);
      load_config(10'd1, 16'd0, 16'd0, 16'd0, 16'd0);
      run_phase(200);
      load_config(10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(150);
      load_config(10'd0, 16'd150, 16'd600, 16'd80, 16'd50);
      run_phase(200);

      // Back-to-back fast shots with no cooling stack heat at the largest step.
      load_config(10'd1023, 16'd200, 16'd833, 16'd0, 16'd100);
      for (int k = 0; k < 60; k++)
         poke(wall_ms + 32'd1, 1'b1, MODE_FAST, 4'b1111, 16'd0, 16'd0, 16'd0);
      drain();

      repeat (4) begin
         load_config(10'($urandom_range(0, 1023)), 16'($urandom_range(0, 400)),
                     16'($urandom_range(0, 1500)), 16'($urandom_range(0, 300)),
                     16'($urandom_range(0, 500)));
         run_phase(200);
      end

      quiet = 1'b1;
      load_config(10'($urandom_range(0, 1023)), 16'($urandom_range(0, 400)),
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 300)),
                  16'($urandom_range(0, 500)));
      run_phase(150);
      repeat (8) @(posedge clock);

      if (sb.errors == 0) begin
         $display("PASS shot_gate_heat_budget");
      end else begin
         $display("FAIL shot_gate_heat_budget");
      end
      $finish;
   end

endmodule
